FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition at one edge implies a condition at the next edge.
`define CHK_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/fpsc_pkg.sv
// Package with the types, widths and codes of the face pose stability check.
`timescale 1ns / 1ps
package fpsc_pkg;

  localparam int Window     = 16;
  localparam int WinBits    = $clog2(Window);
  localparam int PtrW       = WinBits;
  localparam int FillW      = $clog2(Window + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int CountW   = 8;
  localparam int AngleW   = 13;
  localparam int EdgeW    = 11;
  localparam int AreaW    = 22;
  localparam int LimW     = 12;
  localparam int VerdictW = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 22;

  localparam int CntSqElW  = 2 * CountW;
  localparam int CntSumW   = CountW + WinBits;
  localparam int CntSqW    = CntSqElW + WinBits;
  localparam int CntCmpW   = 2 * CntSumW;
  localparam int PoseSqElW = 2 * AngleW - 1;
  localparam int PoseSumW  = AngleW + WinBits;
  localparam int PoseSqW   = PoseSqElW + WinBits;
  localparam int PoseCmpW  = 2 * PoseSumW;
  localparam int AreaSqElW = 2 * AreaW;
  localparam int AreaSumW  = AreaW + WinBits;
  localparam int AreaSqW   = AreaSqElW + WinBits;
  localparam int AreaCmpW  = 2 * AreaSumW;

  typedef enum logic [VerdictW-1:0] {
    V_OK      = 3'd0,
    V_NO_FACE = 3'd1,
    V_SEVERAL = 3'd2,
    V_STEADY  = 3'd3,
    V_FAR     = 3'd4,
    V_POSE    = 3'd5
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POSE_STEADY = 3'd0,
    CFG_YAW         = 3'd1,
    CFG_PITCH       = 3'd2,
    CFG_ROLL        = 3'd3,
    CFG_AREA_STEADY = 3'd4,
    CFG_AREA_MIN    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPD,
    BK_ACC,
    BK_SQ,
    BK_DEC
  } back_state_e;

  typedef struct packed {
    logic [CountW-1:0]        count;
    logic signed [AngleW-1:0] yaw;
    logic signed [AngleW-1:0] pitch;
    logic signed [AngleW-1:0] roll;
    logic [AreaW-1:0]         area;
  } item_t;

  typedef struct packed {
    logic [LimW-1:0]  pose_steady;
    logic [LimW-1:0]  yaw_lim;
    logic [LimW-1:0]  pitch_lim;
    logic [LimW-1:0]  roll_lim;
    logic [AreaW-1:0] area_steady;
    logic [AreaW-1:0] area_min;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/fpsc_front.sv
// Front end: accepts frame words, zeroes pose and area unless one face, forms box area.
`timescale 1ns / 1ps
module fpsc_front (
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fpsc_pkg::CountW-1:0]        face_count_i,
  input  logic signed [fpsc_pkg::AngleW-1:0] yaw_i,
  input  logic signed [fpsc_pkg::AngleW-1:0] pitch_i,
  input  logic signed [fpsc_pkg::AngleW-1:0] roll_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_left_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_right_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_top_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_bottom_i,
  input  fpsc_pkg::q_stat_t                  q_stat_i,
  output logic                               push_o,
  output fpsc_pkg::item_t                    item_o
);
  import fpsc_pkg::*;

  logic             one_face;
  logic [EdgeW-1:0] width, height;
  logic [AreaW-1:0] area;

  // The product of two 11-bit extents never exceeds the 22-bit area range.
  always_comb begin
    one_face = (face_count_i == CountW'(1));
    width    = (box_right_i > box_left_i) ? box_right_i - box_left_i : '0;
    height   = (box_bottom_i > box_top_i) ? box_bottom_i - box_top_i : '0;
    area     = AreaW'(width) * AreaW'(height);
    item_o.count = face_count_i;
    item_o.yaw   = one_face ? yaw_i : '0;
    item_o.pitch = one_face ? pitch_i : '0;
    item_o.roll  = one_face ? roll_i : '0;
    item_o.area  = one_face ? area : '0;
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

FILE: sv/fpsc_queue.sv
// Short queue of classified frame words between the front end and the back end.
`timescale 1ns / 1ps
module fpsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fpsc_pkg::item_t    item_i,
  input  logic               pop_i,
  output fpsc_pkg::item_t    item_o,
  output fpsc_pkg::q_stat_t  stat_o
);
  import fpsc_pkg::*;

  item_t             entry_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);

endmodule

FILE: sv/fpsc_back.sv
// Back end: window update, running sums, squares and the verdict decision.
`timescale 1ns / 1ps
module fpsc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpsc_pkg::cfg_t                cfg_i,
  input  fpsc_pkg::q_stat_t             q_stat_i,
  input  fpsc_pkg::item_t               item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fpsc_pkg::VerdictW-1:0] verdict_o
);
  import fpsc_pkg::*;

  back_state_e state_q, state_d;
  logic        out_load;
  item_t       cur_q;

  logic [CountW-1:0]        cnt_win_q  [Window];
  logic signed [AngleW-1:0] pose_win_q [3][Window];
  logic [AreaW-1:0]         area_win_q [Window];
  logic [PtrW-1:0]          ptr_q;
  logic [FillW-1:0]         fill_q;

  logic [CntSumW-1:0]         cnt_sum_q;
  logic [CntSqW-1:0]          cnt_sq_q;
  logic signed [PoseSumW-1:0] pose_sum_q [3];
  logic [PoseSqW-1:0]         pose_sq_q  [3];
  logic [AreaSumW-1:0]        area_sum_q;
  logic [AreaSqW-1:0]         area_sq_q;

  logic [CntSqElW-1:0]  cnt_new_sq_q, cnt_old_sq_q;
  logic [PoseSqElW-1:0] pose_new_sq_q [3];
  logic [PoseSqElW-1:0] pose_old_sq_q [3];
  logic [AreaSqElW-1:0] area_new_sq_q, area_old_sq_q;

  logic [CntCmpW-1:0]  cnt_ss_q;
  logic [PoseCmpW-1:0] pose_ss_q [3];
  logic [PoseCmpW-1:0] pose_bnd_sq_q;
  logic [AreaCmpW-1:0] area_ss_q, area_bnd_sq_q;

  logic                 out_valid_q;
  logic [VerdictW-1:0]  verdict_q;
  verdict_e             verdict_d;

  logic signed [AngleW-1:0]     new_pose [3];
  logic signed [AngleW-1:0]     old_pose [3];
  logic signed [2*AngleW-1:0]   new_prod [3];
  logic signed [2*AngleW-1:0]   old_prod [3];
  logic [PoseSumW-1:0]          pose_mag [3];
  logic [PoseSumW-1:0]          pose_bnd;
  logic [AreaSumW-1:0]          area_bnd;
  logic [LimW-1:0]              mean_lim [3];
  logic [PoseCmpW-1:0]          pose_spread [3];
  logic [AreaCmpW-1:0]          area_spread;
  logic                         pose_steady, pose_within;

  always_comb begin
    new_pose[0] = cur_q.yaw;
    new_pose[1] = cur_q.pitch;
    new_pose[2] = cur_q.roll;
    mean_lim[0] = cfg_i.yaw_lim;
    mean_lim[1] = cfg_i.pitch_lim;
    mean_lim[2] = cfg_i.roll_lim;
    for (int k = 0; k < 3; k++) begin
      old_pose[k] = pose_win_q[k][ptr_q];
      new_prod[k] = new_pose[k] * new_pose[k];
      old_prod[k] = old_pose[k] * old_pose[k];
      pose_mag[k] = pose_sum_q[k][PoseSumW-1] ? PoseSumW'(-pose_sum_q[k])
                                               : PoseSumW'(pose_sum_q[k]);
    end
    pose_bnd = PoseSumW'(cfg_i.pose_steady) * PoseSumW'(Window);
    area_bnd = AreaSumW'(cfg_i.area_steady) * AreaSumW'(Window);
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = BK_UPD;
        end
      end
      BK_UPD: state_d = BK_ACC;
      BK_ACC: state_d = BK_SQ;
      BK_SQ:  state_d = BK_DEC;
      BK_DEC: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (!q_stat_i.empty) begin
            pop_o   = 1'b1;
            state_d = BK_UPD;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  // Window slots and running sums; the old slot value leaves as the new one enters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        cnt_win_q[i]  <= '0;
        area_win_q[i] <= '0;
        for (int k = 0; k < 3; k++) begin
          pose_win_q[k][i] <= '0;
        end
      end
      for (int k = 0; k < 3; k++) begin
        pose_sum_q[k] <= '0;
        pose_sq_q[k]  <= '0;
      end
      ptr_q      <= '0;
      fill_q     <= '0;
      cnt_sum_q  <= '0;
      cnt_sq_q   <= '0;
      area_sum_q <= '0;
      area_sq_q  <= '0;
    end else if (state_q == BK_UPD) begin
      cnt_win_q[ptr_q]  <= cur_q.count;
      area_win_q[ptr_q] <= cur_q.area;
      cnt_sum_q  <= cnt_sum_q - CntSumW'(cnt_win_q[ptr_q]) + CntSumW'(cur_q.count);
      area_sum_q <= area_sum_q - AreaSumW'(area_win_q[ptr_q]) + AreaSumW'(cur_q.area);
      for (int k = 0; k < 3; k++) begin
        pose_win_q[k][ptr_q] <= new_pose[k];
        pose_sum_q[k] <= pose_sum_q[k] - PoseSumW'(old_pose[k]) + PoseSumW'(new_pose[k]);
      end
      ptr_q  <= (ptr_q == PtrW'(Window - 1)) ? '0 : ptr_q + PtrW'(1);
      fill_q <= (fill_q == FillW'(Window)) ? fill_q : fill_q + FillW'(1);
    end else if (state_q == BK_ACC) begin
      cnt_sq_q  <= cnt_sq_q - CntSqW'(cnt_old_sq_q) + CntSqW'(cnt_new_sq_q);
      area_sq_q <= area_sq_q - AreaSqW'(area_old_sq_q) + AreaSqW'(area_new_sq_q);
      for (int k = 0; k < 3; k++) begin
        pose_sq_q[k] <= pose_sq_q[k] - PoseSqW'(pose_old_sq_q[k])
                        + PoseSqW'(pose_new_sq_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_UPD) begin
      cnt_new_sq_q  <= CntSqElW'(cur_q.count) * CntSqElW'(cur_q.count);
      cnt_old_sq_q  <= CntSqElW'(cnt_win_q[ptr_q]) * CntSqElW'(cnt_win_q[ptr_q]);
      area_new_sq_q <= AreaSqElW'(cur_q.area) * AreaSqElW'(cur_q.area);
      area_old_sq_q <= AreaSqElW'(area_win_q[ptr_q]) * AreaSqElW'(area_win_q[ptr_q]);
      for (int k = 0; k < 3; k++) begin
        pose_new_sq_q[k] <= new_prod[k][PoseSqElW-1:0];
        pose_old_sq_q[k] <= old_prod[k][PoseSqElW-1:0];
      end
    end
    if (state_q == BK_SQ) begin
      cnt_ss_q      <= CntCmpW'(cnt_sum_q) * CntCmpW'(cnt_sum_q);
      area_ss_q     <= AreaCmpW'(area_sum_q) * AreaCmpW'(area_sum_q);
      area_bnd_sq_q <= AreaCmpW'(area_bnd) * AreaCmpW'(area_bnd);
      pose_bnd_sq_q <= PoseCmpW'(pose_bnd) * PoseCmpW'(pose_bnd);
      for (int k = 0; k < 3; k++) begin
        pose_ss_q[k] <= PoseCmpW'(pose_mag[k]) * PoseCmpW'(pose_mag[k]);
      end
    end
  end

  always_comb begin
    area_spread = AreaCmpW'(Window) * AreaCmpW'(area_sq_q) - area_ss_q;
    pose_steady = 1'b1;
    pose_within = 1'b1;
    for (int k = 0; k < 3; k++) begin
      pose_spread[k] = PoseCmpW'(Window) * PoseCmpW'(pose_sq_q[k]) - pose_ss_q[k];
      if (!(pose_spread[k] < pose_bnd_sq_q)) begin
        pose_steady = 1'b0;
      end
      if (!(pose_mag[k] < PoseSumW'(mean_lim[k]) * PoseSumW'(Window))) begin
        pose_within = 1'b0;
      end
    end
    if (fill_q != FillW'(Window)) begin
      verdict_d = V_STEADY;
    end else if (CntCmpW'(Window) * CntCmpW'(cnt_sq_q) != cnt_ss_q) begin
      verdict_d = V_STEADY;
    end else if (cnt_sum_q == '0) begin
      verdict_d = V_NO_FACE;
    end else if (cnt_sum_q != CntSumW'(Window)) begin
      verdict_d = V_SEVERAL;
    end else if (!(area_spread < area_bnd_sq_q)) begin
      verdict_d = V_STEADY;
    end else if (!(area_sum_q > AreaSumW'(cfg_i.area_min) * AreaSumW'(Window))) begin
      verdict_d = V_FAR;
    end else if (!pose_steady) begin
      verdict_d = V_STEADY;
    end else if (pose_within) begin
      verdict_d = V_OK;
    end else begin
      verdict_d = V_POSE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

FILE: sv/face_pose_stability_check.sv
// Top level of the face pose stability check: configuration registers and the two halves.
//
// Usage: one input word per video frame on the in channel (in_valid_i / in_stall_o)
// carries the face count, yaw, pitch, roll and the face box. Each word yields
// exactly one verdict word on the out channel (out_valid_o / out_stall_i).
// A word is taken at a rising edge with valid high and stall low.
// A word passes through the queue, the back-end steps (window update, square-sum
// update, squaring of the sums, decision) and the verdict register. The back end
// takes no new word before its decision step for the last one. A two-entry queue
// sits between the front end and the back end. While the receiver stalls, the
// verdict register holds its word, the back end waits in its decision step, and
// the queue fills; in_stall_o rises once the queue is full. Reset clears the
// windows, running sums and queue and loads the default limits. Limits are to be
// written through cfg_we_i / cfg_index_i / cfg_data_i only while the block is idle;
// the block does not enforce this. Unknown indexes are ignored.
`timescale 1ns / 1ps
module face_pose_stability_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fpsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fpsc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fpsc_pkg::CountW-1:0]        face_count_i,
  input  logic signed [fpsc_pkg::AngleW-1:0] yaw_i,
  input  logic signed [fpsc_pkg::AngleW-1:0] pitch_i,
  input  logic signed [fpsc_pkg::AngleW-1:0] roll_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_left_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_right_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_top_i,
  input  logic [fpsc_pkg::EdgeW-1:0]         box_bottom_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [fpsc_pkg::VerdictW-1:0]      verdict_o
);
  import fpsc_pkg::*;

  cfg_t    cfg_q;
  q_stat_t q_stat;
  item_t   push_item, pop_item;
  logic    push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pose_steady <= LimW'(48);
      cfg_q.yaw_lim     <= LimW'(480);
      cfg_q.pitch_lim   <= LimW'(320);
      cfg_q.roll_lim    <= LimW'(480);
      cfg_q.area_steady <= AreaW'(307);
      cfg_q.area_min    <= AreaW'(1536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POSE_STEADY: cfg_q.pose_steady <= cfg_data_i[LimW-1:0];
        CFG_YAW:         cfg_q.yaw_lim     <= cfg_data_i[LimW-1:0];
        CFG_PITCH:       cfg_q.pitch_lim   <= cfg_data_i[LimW-1:0];
        CFG_ROLL:        cfg_q.roll_lim    <= cfg_data_i[LimW-1:0];
        CFG_AREA_STEADY: cfg_q.area_steady <= cfg_data_i[AreaW-1:0];
        CFG_AREA_MIN:    cfg_q.area_min    <= cfg_data_i[AreaW-1:0];
        default: ;
      endcase
    end
  end

  fpsc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .face_count_i (face_count_i),
    .yaw_i        (yaw_i),
    .pitch_i      (pitch_i),
    .roll_i       (roll_i),
    .box_left_i   (box_left_i),
    .box_right_i  (box_right_i),
    .box_top_i    (box_top_i),
    .box_bottom_i (box_bottom_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .item_o       (push_item)
  );

  fpsc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  fpsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

endmodule

FILE: sv/fpsc_checker.sv
// Port-level checker for the face pose stability check, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fpsc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [fpsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input logic [fpsc_pkg::CfgDataW-1:0]      cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [fpsc_pkg::CountW-1:0]        face_count_i,
  input logic signed [fpsc_pkg::AngleW-1:0] yaw_i,
  input logic signed [fpsc_pkg::AngleW-1:0] pitch_i,
  input logic signed [fpsc_pkg::AngleW-1:0] roll_i,
  input logic [fpsc_pkg::EdgeW-1:0]         box_left_i,
  input logic [fpsc_pkg::EdgeW-1:0]         box_right_i,
  input logic [fpsc_pkg::EdgeW-1:0]         box_top_i,
  input logic [fpsc_pkg::EdgeW-1:0]         box_bottom_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [fpsc_pkg::VerdictW-1:0]      verdict_o
);
  import fpsc_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] pending_q, pending_d;

  // Words accepted but not yet answered: queue, back end and verdict register.
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `CHK_ASSERT_NEXT(a_valid_held, out_valid_o && out_stall_i, out_valid_o, "verdict dropped")
  `CHK_ASSERT_NEXT(a_word_held, out_valid_o && out_stall_i, $stable(verdict_o), "verdict changed")
  `CHK_ASSERT(a_no_extra, !out_acc || (pending_q != 3'd0), "verdict without a frame")
  `CHK_ASSERT(a_bounded, pending_q <= 3'd4, "too many frames in flight")

endmodule

bind face_pose_stability_check fpsc_checker u_fpsc_checker (.*);

FILE: test/face_pose_stability_check_tb.sv
// Testbench for the face pose stability check: random and directed frames against a predictor.
`timescale 1ns / 1ps
module face_pose_stability_check_tb;
  import fpsc_pkg::*;

  localparam int Depth = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CountW-1:0] face_count_i = '0;
  logic signed [AngleW-1:0] yaw_i = '0, pitch_i = '0, roll_i = '0;
  logic [EdgeW-1:0] box_left_i = '0, box_right_i = '0, box_top_i = '0, box_bottom_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VerdictW-1:0] verdict_o;

  face_pose_stability_check DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  logic [11:0] lim_pose, lim_yaw, lim_pitch, lim_roll;
  logic [21:0] lim_area_sd, lim_area_min;
  logic [7:0] hist_count [Depth];
  longint hist_angle [3][Depth];
  longint hist_area [Depth];
  int slot_ptr, frames_in;
  longint count_acc, count_sq_acc, area_acc, area_sq_acc;
  longint angle_acc [3];
  longint angle_sq_acc [3];

  verdict_e pending_verdicts [$];
  int errors = 0;
  bit hold_off = 1'b0;

  function automatic bit spread_ok(longint sq, longint s, longint limit);
    longint sa, spread, bound;
    sa = s < 0 ? -s : s;
    spread = Depth * sq - sa * sa;
    bound = limit * Depth;
    return spread < bound * bound;
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < Depth; i++) begin
      hist_count[i] = 0;
      hist_area[i] = 0;
      for (int k = 0; k < 3; k++) hist_angle[k][i] = 0;
    end
    slot_ptr = 0; frames_in = 0;
    count_acc = 0; count_sq_acc = 0; area_acc = 0; area_sq_acc = 0;
    for (int k = 0; k < 3; k++) begin
      angle_acc[k] = 0; angle_sq_acc[k] = 0;
    end
    lim_pose = 48; lim_yaw = 480; lim_pitch = 320; lim_roll = 480;
    lim_area_sd = 307; lim_area_min = 1536;
  endfunction

  function automatic void apply_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_POSE_STEADY: lim_pose = val[11:0];
      CFG_YAW:         lim_yaw = val[11:0];
      CFG_PITCH:       lim_pitch = val[11:0];
      CFG_ROLL:        lim_roll = val[11:0];
      CFG_AREA_STEADY: lim_area_sd = val;
      CFG_AREA_MIN:    lim_area_min = val;
      default: ;
    endcase
  endfunction

  function automatic verdict_e judge_frame(logic [7:0] cnt, logic signed [12:0] y,
      logic signed [12:0] p, logic signed [12:0] r, logic [10:0] l, logic [10:0] rt,
      logic [10:0] t, logic [10:0] b);
    longint ang [3];
    longint area, w, h, old;
    bit pose_steady;
    ang = '{0, 0, 0};
    area = 0;
    if (cnt == 1) begin
      w = rt > l ? rt - l : 0;
      h = b > t ? b - t : 0;
      area = w * h > 4194303 ? 4194303 : w * h;
      ang[0] = y; ang[1] = p; ang[2] = r;
    end
    old = hist_count[slot_ptr];
    count_acc += cnt - old;
    count_sq_acc += cnt * cnt - old * old;
    hist_count[slot_ptr] = cnt;
    for (int k = 0; k < 3; k++) begin
      old = hist_angle[k][slot_ptr];
      angle_acc[k] += ang[k] - old;
      angle_sq_acc[k] += ang[k] * ang[k] - old * old;
      hist_angle[k][slot_ptr] = ang[k];
    end
    old = hist_area[slot_ptr];
    area_acc += area - old;
    area_sq_acc += area * area - old * old;
    hist_area[slot_ptr] = area;
    slot_ptr = (slot_ptr + 1) % Depth;
    if (frames_in < Depth) frames_in++;
    if (frames_in < Depth) return V_STEADY;
    if (Depth * count_sq_acc != count_acc * count_acc) return V_STEADY;
    if (count_acc == 0) return V_NO_FACE;
    if (count_acc != Depth) return V_SEVERAL;
    if (!spread_ok(area_sq_acc, area_acc, lim_area_sd)) return V_STEADY;
    if (!(area_acc > longint'(lim_area_min) * Depth)) return V_FAR;
    pose_steady = 1'b1;
    for (int k = 0; k < 3; k++)
      if (!spread_ok(angle_sq_acc[k], angle_acc[k], lim_pose)) pose_steady = 1'b0;
    if (!pose_steady) return V_STEADY;
    if ((angle_acc[0] < 0 ? -angle_acc[0] : angle_acc[0]) < longint'(lim_yaw) * Depth &&
        (angle_acc[1] < 0 ? -angle_acc[1] : angle_acc[1]) < longint'(lim_pitch) * Depth &&
        (angle_acc[2] < 0 ? -angle_acc[2] : angle_acc[2]) < longint'(lim_roll) * Depth)
      return V_OK;
    return V_POSE;
  endfunction

  task automatic send_word(logic [7:0] cnt, logic signed [12:0] y, logic signed [12:0] p,
      logic signed [12:0] r, logic [10:0] l, logic [10:0] rt, logic [10:0] t,
      logic [10:0] b);
    in_valid_i <= 1'b1;
    face_count_i <= cnt; yaw_i <= y; pitch_i <= p; roll_i <= r;
    box_left_i <= l; box_right_i <= rt; box_top_i <= t; box_bottom_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_verdicts = {pending_verdicts, judge_frame(cnt, y, p, r, l, rt, t, b)};
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_limit(idx, val);
  endtask

  // A single face with random jitter around a base pose and box.
  task automatic send_face(int yb, int pb, int rb, int jit, int bw, int bj);
    int l, t;
    l = $urandom_range(0, 200); t = $urandom_range(0, 200);
    send_word(8'd1, 13'(yb + $urandom_range(0, 2 * jit) - jit),
              13'(pb + $urandom_range(0, 2 * jit) - jit),
              13'(rb + $urandom_range(0, 2 * jit) - jit),
              11'(l), 11'(l + bw + $urandom_range(0, bj)), 11'(t),
              11'(t + bw + $urandom_range(0, bj)));
  endtask

  task automatic send_noise();
    send_word(8'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
              11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
  endtask

  task automatic test_directed();
    send_word(8'd0, 13'sd0, 13'sd0, 13'sd0, 11'd0, 11'd0, 11'd0, 11'd0);
    send_word(8'd255, -13'sd4096, 13'sd4095, -13'sd2880, 11'd2047, 11'd0, 11'd2047, 11'd0);
    send_word(8'd1, 13'sd2880, -13'sd2880, 13'sd4095, 11'd0, 11'd2047, 11'd0, 11'd2047);
    send_word(8'd1, -13'sd4096, -13'sd4096, -13'sd4096, 11'd500, 11'd100, 11'd0, 11'd50);
    send_word(8'd2, 13'sd100, 13'sd100, 13'sd100, 11'd0, 11'd100, 11'd0, 11'd100);
    drain();
    for (int i = 0; i < 18; i++)
      send_word(8'd0, 13'sd5, 13'sd5, 13'sd5, 11'd0, 11'd9, 11'd0, 11'd9);
    for (int i = 0; i < 18; i++)
      send_word(8'd3, 13'sd0, 13'sd0, 13'sd0, 11'd0, 11'd0, 11'd0, 11'd0);
    drain();
  endtask

  task automatic test_steady_faces();
    for (int i = 0; i < 20; i++) send_face(0, 0, 0, 1, 100, 0);
    for (int i = 0; i < 20; i++) send_face(900, 0, 0, 1, 100, 0);
    for (int i = 0; i < 20; i++) send_face(0, 0, 0, 1, 20, 0);
    for (int i = 0; i < 20; i++) send_face(0, 0, 0, 200, 100, 0);
    drain();
  endtask

  task automatic run_mix(int frames);
    int burst, mode;
    for (int i = 0; i < frames; ) begin
      burst = $urandom_range(1, 30);
      mode = $urandom_range(0, 9);
      for (int j = 0; j < burst; j++) begin
        if (mode < 6)
          send_face(mode < 3 ? 0 : $urandom_range(0, 1200) - 600, 0,
                    $urandom_range(0, 200) - 100, $urandom_range(0, 60),
                    $urandom_range(10, 120), $urandom_range(0, 8));
        else if (mode == 6) send_word(8'd0, '0, '0, '0, '0, '0, '0, '0);
        else if (mode == 7) send_word(8'($urandom_range(2, 4)), '0, '0, '0, '0, '0, '0, '0);
        else send_noise();
      end
      i += burst;
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
  endtask

  task automatic test_random_limits();
    write_limit(CFG_POSE_STEADY, 22'h3FFFFF);
    write_limit(CFG_YAW, 22'd4095);
    write_limit(CFG_PITCH, 22'd0);
    write_limit(CFG_ROLL, 22'd2880);
    write_limit(CFG_AREA_STEADY, 22'h3FFFFF);
    write_limit(CFG_AREA_MIN, 22'd0);
    write_limit(3'd7, 22'd123);
    run_mix(400);
    drain();
    write_limit(CFG_POSE_STEADY, 22'd30);
    write_limit(CFG_YAW, 22'd300);
    write_limit(CFG_PITCH, 22'd2880);
    write_limit(CFG_ROLL, 22'd200);
    write_limit(CFG_AREA_STEADY, 22'd200);
    write_limit(CFG_AREA_MIN, 22'd900);
    run_mix(400);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send_face(0, 0, 0, 2, 60, 0);
    in_valid_i <= 1'b0;
    drain();
    write_limit(CFG_POSE_STEADY, 22'd0);
    write_limit(CFG_AREA_MIN, 22'h3FFFFF);
    run_mix(150);
    drain();
    write_limit(CFG_POSE_STEADY, 22'd48);
    write_limit(CFG_AREA_MIN, 22'd1536);
    run_mix(450);
    drain();
  endtask

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict %0d with no word pending", verdict_o);
        errors++;
      end else begin
        if (verdict_o !== pending_verdicts[0]) begin
          $error("verdict: expected %0d, got %0d", pending_verdicts[0], verdict_o);
          errors++;
        end
        void'(pending_verdicts.pop_front());
      end
    end
  end

  initial begin
    clear_history();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_steady_faces();
    test_random_limits();
    test_backpressure();
    if (errors == 0 && pending_verdicts.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: face_pose_stability_check.f
+incdir+sv
sv/fpsc_pkg.sv
sv/fpsc_front.sv
sv/fpsc_queue.sv
sv/fpsc_back.sv
sv/face_pose_stability_check.sv
sv/fpsc_checker.sv
test/face_pose_stability_check_tb.sv
